### src/srx_pkg.sv
// Shared types, sync constants and the CRC-16/MODBUS byte update for the frame receiver.
package srx_pkg;

  localparam logic [7:0]  SyncA    = 8'hAA;
  localparam logic [7:0]  SyncB    = 8'hBB;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  // One received byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } srx_item_t;

  // Reflected CRC update over one byte, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/srx_in_stage.sv
// Input register that holds one received byte until the frame logic takes it.
module srx_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               take_i,
  output srx_pkg::srx_item_t item_o
);

  logic       valid_q;
  logic [7:0] data_q;

  assign in_stall_o = valid_q && !take_i;
  assign item_o     = '{valid: valid_q, data: data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= 8'h00;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
      if (in_valid_i) begin
        data_q <= rx_byte_i;
      end
    end
  end

endmodule

### src/srx_frame_fsm.sv
// Frame phase machine, running CRC and the result register.
module srx_frame_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srx_pkg::srx_item_t item_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         frame_byte_o,
  output logic               first_of_frame_o,
  output logic               last_of_frame_o,
  output logic               crc_good_o
);

  typedef enum logic [2:0] {
    PhHunt, PhSync2, PhType, PhLenLo, PhLenHi, PhPayload, PhCrcLo, PhCrcHi
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] length_q, length_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        first_q, last_q, good_q;
  logic        emit, first_d, last_d, good_d;
  logic        fire;
  logic [15:0] crc_next;
  logic [15:0] len_full;
  logic [16:0] count_inc;
  logic [7:0]  b;

  assign b         = item_i.data;
  assign take_o    = !out_valid_q || !out_stall_i;
  assign fire      = item_i.valid && take_o;
  assign crc_next  = srx_pkg::crc_feed(crc_q, b);
  assign len_full  = {b, length_q[7:0]};
  assign count_inc = {1'b0, count_q} + 17'd1;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    length_d = length_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    emit     = 1'b1;
    first_d  = 1'b0;
    last_d   = 1'b0;
    good_d   = 1'b0;
    case (phase_q)
      PhHunt: begin
        emit = 1'b0;
        if (b == srx_pkg::SyncA) begin
          crc_d   = srx_pkg::crc_feed(srx_pkg::CrcInit, b);
          phase_d = PhSync2;
        end
      end
      PhSync2: begin
        emit = 1'b0;
        if (b == srx_pkg::SyncB) begin
          crc_d   = crc_next;
          phase_d = PhType;
        end else begin
          crc_d   = srx_pkg::CrcInit;
          phase_d = PhHunt;
        end
      end
      PhType: begin
        crc_d   = crc_next;
        first_d = 1'b1;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        crc_d    = crc_next;
        length_d = {8'h00, b};
        phase_d  = PhLenHi;
      end
      PhLenHi: begin
        crc_d    = crc_next;
        length_d = len_full;
        count_d  = 16'h0000;
        phase_d  = (len_full == 16'h0000) ? PhCrcLo : PhPayload;
      end
      PhPayload: begin
        crc_d   = crc_next;
        count_d = count_inc[15:0];
        if (count_inc >= {1'b0, length_q}) begin
          phase_d = PhCrcLo;
        end
      end
      PhCrcLo: begin
        crc_lo_d = b;
        phase_d  = PhCrcHi;
      end
      PhCrcHi: begin
        last_d  = 1'b1;
        good_d  = ({b, crc_lo_q} == crc_q);
        phase_d = PhHunt;
        crc_d   = srx_pkg::CrcInit;
        count_d = 16'h0000;
      end
      default: begin
        emit    = 1'b0;
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      count_q     <= 16'h0000;
      length_q    <= 16'h0000;
      crc_q       <= srx_pkg::CrcInit;
      crc_lo_q    <= 8'h00;
      out_valid_q <= 1'b0;
      byte_q      <= 8'h00;
      first_q     <= 1'b0;
      last_q      <= 1'b0;
      good_q      <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= fire && emit;
      if (fire) begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        length_q <= length_d;
        crc_q    <= crc_d;
        crc_lo_q <= crc_lo_d;
        byte_q   <= b;
        first_q  <= first_d;
        last_q   <= last_d;
        good_q   <= good_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_byte_o     = byte_q;
  assign first_of_frame_o = first_q;
  assign last_of_frame_o  = last_q;
  assign crc_good_o       = good_q;

endmodule

### src/sync_length_crc16_frame_receiver_unit.sv
// Top level of the sync, length and CRC-16/MODBUS framed packet receiver.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i, in_stall_o  rx_byte_i
//   output   out        out_valid_o, out_stall_i frame_byte_o, first_of_frame_o,
//                                               last_of_frame_o, crc_good_o
//
// A received byte passes through two registers: the input register, then the
// result register, which is loaded by the phase machine and the CRC update
// together. A byte held in the input register moves into the result register
// once that register is empty or not stalled, and is on the output from then
// on; one byte can be taken in every cycle while the output does not stall.
// Reset clears the phase to hunting and the running CRC to 0xFFFF.
// A stall on the output holds the result register; the input register keeps
// taking bytes until it is itself full, and only then is in_stall_o raised.
// Sync bytes and noise produce no output transaction.
module sync_length_crc16_frame_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       first_of_frame_o,
  output logic       last_of_frame_o,
  output logic       crc_good_o
);

  srx_pkg::srx_item_t item;
  logic               take;

  // Input register: decouples the sender from stalls on the result side.
  srx_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i (rx_byte_i),
    .take_i    (take),
    .item_o    (item)
  );

  // Phase machine, CRC accumulation and the result register.
  srx_frame_fsm u_frame_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_byte_o    (frame_byte_o),
    .first_of_frame_o(first_of_frame_o),
    .last_of_frame_o (last_of_frame_o),
    .crc_good_o      (crc_good_o)
  );

  // The input side only stalls when the result register is full and held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could advance");

  // A frame never starts and ends on the same byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(first_of_frame_o && last_of_frame_o))
    else $error("first and last flags set on one byte");

  // The CRC verdict is only reported on the closing byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_frame_o) |-> !crc_good_o)
    else $error("crc_good set on a byte other than the last");

  // After the closing byte is delivered, the next byte out cannot be a middle byte
  // unless a new frame has started first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_frame_o) |=>
      (!out_valid_o || first_of_frame_o))
    else $error("frame byte delivered directly after the end of a frame");

endmodule

### bench/tb.sv
// Self-checking testbench for the sync, length and CRC-16/MODBUS frame receiver.
`timescale 1ns / 100ps

module tb;

  // Phases of the receiver as the checker tracks them.
  typedef enum logic [2:0] {
    PhHunt, PhSync2, PhType, PhLenLo, PhLenHi, PhPayload, PhCrcLo, PhCrcHi
  } rx_phase_e;

  // One output transaction: the echoed frame byte and its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       good;
  } frame_out_t;

  // The timeout is far beyond the slowest legal run, with every gap and
  // stall at its longest.
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned RandomItems = 1600;
  localparam int unsigned CalmFrom    = 1350;
  localparam int unsigned DrainCycles = 10;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] frame_byte_o;
  logic       first_of_frame_o;
  logic       last_of_frame_o;
  logic       crc_good_o;

  // Bytes waiting to be offered, and output transactions still owed by the block.
  logic [7:0]  rx_pending [$];
  frame_out_t  frame_bytes_due [$];

  // Byte-wise lookup table for the reflected CRC, filled before any use.
  logic [15:0] crc_lut [256];

  // The checker's own copy of the receiver state.
  rx_phase_e   trk_phase;
  logic [16:0] trk_count;
  logic [15:0] trk_length;
  logic [15:0] trk_crc;
  logic [7:0]  trk_crc_lo;

  logic        calm = 1'b0;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned bytes_taken;
  int unsigned results_checked;
  int unsigned good_frames_seen;
  int unsigned bad_frames_seen;
  int unsigned frames_queued;
  int unsigned planned;
  frame_out_t  got;
  frame_out_t  want;

  sync_length_crc16_frame_receiver_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .frame_byte_o    (frame_byte_o),
    .first_of_frame_o(first_of_frame_o),
    .last_of_frame_o (last_of_frame_o),
    .crc_good_o      (crc_good_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Table-driven CRC-16/MODBUS step over one byte.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_lut[crc[7:0] ^ b];
  endfunction

  // Advances the tracked receiver state by one accepted byte and records the
  // output transaction that the byte must cause, if any.
  task automatic predict_rx_byte(input logic [7:0] b);
    frame_out_t r;
    logic       emits;
    r     = '{data: b, first: 1'b0, last: 1'b0, good: 1'b0};
    emits = 1'b1;
    case (trk_phase)
      PhHunt: begin
        emits = 1'b0;
        if (b == srx_pkg::SyncA) begin
          trk_crc   = crc16_step(srx_pkg::CrcInit, b);
          trk_phase = PhSync2;
        end
      end
      PhSync2: begin
        // Anything but the second sync byte, a repeated first sync byte
        // included, throws the pair away.
        emits = 1'b0;
        if (b == srx_pkg::SyncB) begin
          trk_crc   = crc16_step(trk_crc, b);
          trk_phase = PhType;
        end else begin
          trk_crc   = srx_pkg::CrcInit;
          trk_phase = PhHunt;
        end
      end
      PhType: begin
        trk_crc   = crc16_step(trk_crc, b);
        r.first   = 1'b1;
        trk_phase = PhLenLo;
      end
      PhLenLo: begin
        trk_crc    = crc16_step(trk_crc, b);
        trk_length = {8'h00, b};
        trk_phase  = PhLenHi;
      end
      PhLenHi: begin
        trk_crc    = crc16_step(trk_crc, b);
        trk_length = {b, trk_length[7:0]};
        trk_count  = '0;
        trk_phase  = (trk_length == 16'd0) ? PhCrcLo : PhPayload;
      end
      PhPayload: begin
        trk_crc   = crc16_step(trk_crc, b);
        trk_count = trk_count + 17'd1;
        if (trk_count >= {1'b0, trk_length}) begin
          trk_phase = PhCrcLo;
        end
      end
      PhCrcLo: begin
        trk_crc_lo = b;
        trk_phase  = PhCrcHi;
      end
      default: begin
        r.last    = 1'b1;
        r.good    = ({b, trk_crc_lo} == trk_crc);
        trk_phase = PhHunt;
        trk_crc   = srx_pkg::CrcInit;
        trk_count = '0;
      end
    endcase
    if (emits) begin
      frame_bytes_due.push_back(r);
    end
  endtask

  // Queues a whole frame: sync pair, type, length, payload and CRC. Payload
  // bytes lean towards the sync values and the extremes now and then. A
  // non-zero corruption mask spoils the CRC on the wire.
  task automatic queue_frame(input logic [7:0] kind, input logic [15:0] len,
                             input logic [15:0] corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = srx_pkg::CrcInit;
    rx_pending.push_back(srx_pkg::SyncA);
    rx_pending.push_back(srx_pkg::SyncB);
    rx_pending.push_back(kind);
    rx_pending.push_back(len[7:0]);
    rx_pending.push_back(len[15:8]);
    crc = crc16_step(crc, srx_pkg::SyncA);
    crc = crc16_step(crc, srx_pkg::SyncB);
    crc = crc16_step(crc, kind);
    crc = crc16_step(crc, len[7:0]);
    crc = crc16_step(crc, len[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      case ($urandom_range(0, 9))
        0:       b = srx_pkg::SyncA;
        1:       b = srx_pkg::SyncB;
        2:       b = 8'h00;
        3:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      rx_pending.push_back(b);
      crc = crc16_step(crc, b);
    end
    crc = crc ^ corrupt;
    rx_pending.push_back(crc[7:0]);
    rx_pending.push_back(crc[15:8]);
    frames_queued++;
  endtask

  // Holds the stimulus back until every queued byte has been taken and every
  // output transaction it owes has arrived.
  task automatic wait_until_drained();
    while (rx_pending.size() != 0 || in_valid || frame_bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender: offers one byte at a time from the pending queue. A byte on
  // offer is held until the block takes it; new choices are made only once
  // the channel is free. Idle bursts are inserted at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output transaction against the oldest expectation,
  // field by field, and stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        got = '{data: frame_byte_o, first: first_of_frame_o,
                last: last_of_frame_o, good: crc_good_o};
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected output transaction: frame_byte %02h", got.data);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          results_checked++;
          if (got.data !== want.data) begin
            $error("frame_byte: expected %02h, actual %02h", want.data, got.data);
            mismatches++;
          end
          if (got.first !== want.first) begin
            $error("first_of_frame: expected %0b, actual %0b", want.first, got.first);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_of_frame: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
          end
          if (got.good !== want.good) begin
            $error("crc_good: expected %0b, actual %0b", want.good, got.good);
            mismatches++;
          end
          if (want.last) begin
            if (want.good) good_frames_seen++;
            else bad_frames_seen++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a hung block or a lost transaction ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[sync_length_crc16_frame_receiver_unit] ERROR");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [15:0] c;
    logic [15:0] len;
    logic [7:0]  b;
    logic        pause_done;

    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ srx_pkg::CrcPoly) : (c >> 1);
      end
      crc_lut[i] = c;
    end
    trk_phase  = PhHunt;
    trk_count  = '0;
    trk_length = '0;
    trk_crc    = srx_pkg::CrcInit;
    trk_crc_lo = '0;
    mismatches = 0;
    pause_done = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Noise while hunting must vanish without a trace.
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(srx_pkg::SyncB);
    // A repeated first sync byte is not a second sync byte; the trailing
    // second sync byte is then mere noise.
    rx_pending.push_back(srx_pkg::SyncA);
    rx_pending.push_back(srx_pkg::SyncA);
    rx_pending.push_back(srx_pkg::SyncB);
    rx_pending.push_back(srx_pkg::SyncA);
    rx_pending.push_back(8'h00);
    // Zero payload length with type 0x00, then type 0xFF with a short payload,
    // then a frame whose CRC arrives spoilt.
    queue_frame(8'h00, 16'd0, 16'h0000);
    queue_frame(8'hFF, 16'd2, 16'h0000);
    queue_frame(8'h5A, 16'd1, 16'h8001);
    wait_until_drained();

    // Random part: mostly well-formed frames with random content, the rest
    // noise, broken sync pairs, spoilt CRCs and frames cut short.
    planned = 0;
    while (planned < RandomItems) begin
      len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 300))
                                         : 16'($urandom_range(0, 12));
      case ($urandom_range(0, 19))
        0, 1: begin
          queue_frame(8'($urandom), len, 16'($urandom_range(1, 16'hFFFF)));
          planned += int'(len) + 5;
        end
        2, 3: begin
          repeat ($urandom_range(1, 5)) begin
            b = ($urandom_range(0, 3) == 0) ? srx_pkg::SyncB : 8'($urandom);
            rx_pending.push_back(b == srx_pkg::SyncA ? 8'h55 : b);
          end
        end
        4: begin
          rx_pending.push_back(srx_pkg::SyncA);
          b = 8'($urandom);
          rx_pending.push_back(b == srx_pkg::SyncB ? srx_pkg::SyncA : b);
        end
        5: begin
          // A frame cut short: whatever follows is taken as its remainder.
          len = 16'($urandom_range(0, 4));
          queue_frame(8'($urandom), len, 16'h0000);
          repeat ($urandom_range(1, int'(len) + 6)) void'(rx_pending.pop_back());
          planned += int'(len) + 3;
        end
        default: begin
          queue_frame(8'($urandom), len, 16'h0000);
          planned += int'(len) + 5;
        end
      endcase
      if (!pause_done && planned >= RandomItems / 2) begin
        // Let everything settle, then send one frame whose length has a
        // non-zero high byte, so the payload count crosses a byte boundary.
        wait_until_drained();
        queue_frame(8'hC3, 16'd256, 16'h0000);
        planned += 261;
        pause_done = 1'b1;
      end
      if (planned >= CalmFrom) begin
        calm = 1'b1;
      end
      while (rx_pending.size() > 32) @(posedge clk_i);
    end

    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Took %0d bytes in %0d frames; checked %0d output transactions.",
             bytes_taken, frames_queued, results_checked);
    $display("Frames ended with good CRC: %0d, with bad CRC: %0d.",
             good_frames_seen, bad_frames_seen);
    if (mismatches == 0) begin
      $display("[sync_length_crc16_frame_receiver_unit] OK");
    end else begin
      $display("[sync_length_crc16_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/srx_pkg.sv
src/srx_in_stage.sv
src/srx_frame_fsm.sv
src/sync_length_crc16_frame_receiver_unit.sv
bench/tb.sv
